/* rtl/windowed_rms_min_max_tracker_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef WINDOWED_RMS_MIN_MAX_TRACKER_CORE_MACROS_SVH
`define WINDOWED_RMS_MIN_MAX_TRACKER_CORE_MACROS_SVH
// Asserts that a condition implies a consequence in the next cycle.
`define WRT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);
// Asserts that a condition implies a consequence in the same cycle.
`define WRT_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);
`endif

/* rtl/wrmmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmmt_pkg
// Shared types for the windowed RMS / min / max tracker.
// ----------------------------------------------------------------------------
package wrmmt_pkg;
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;
endpackage

/* rtl/windowed_rms_min_max_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_min_max_tracker_core
// Tracks RMS over recent sum-of-squares blocks and min/max over recent
// peak blocks; one result beat per sample beat.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata[11:0] sample
// m_axis    out  tdata[11:0] rms_value, [23:12] min_value, [35:24] max_value
//
// After the accepting edge a sample passes through the update, the ring scan
// over memory, a restoring divide of TW = 2*SAMPLE_BITS + clog2(RMS_BLOCK_LEN+1) +
// clog2(RMS_BLOCKS+1) bits and a bit-serial square root, then the result state
// and the idle state.
// rst is synchronous and clears the state machine, the update counters, block
// extremes, accumulator and ring pointers; the scan, divide and root registers
// and the ring memories are not cleared. A result waits in the output register
// until taken; the next sample is accepted once the result is taken.
module windowed_rms_min_max_tracker_core #(
  parameter int SAMPLE_BITS    = 12,
  parameter int RMS_BLOCK_LEN  = 50,
  parameter int RMS_BLOCKS     = 10,
  parameter int PEAK_BLOCK_LEN = 100,
  parameter int PEAK_BLOCKS    = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,   // [11:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] rms, [23:12] min, [35:24] max
  output logic [((3 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import wrmmt_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int MW  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int SQW = 2 * SB + $clog2(RMS_BLOCK_LEN + 1);
  localparam int TW  = SQW + $clog2(RMS_BLOCKS + 1);
  localparam int IW  = $clog2(PEAK_BLOCK_LEN);
  localparam int RIW = $clog2(RMS_BLOCK_LEN);
  localparam int RPW = (RMS_BLOCKS > 1) ? $clog2(RMS_BLOCKS) : 1;
  localparam int PPW = (PEAK_BLOCKS > 1) ? $clog2(PEAK_BLOCKS) : 1;
  localparam int RFW = $clog2(RMS_BLOCKS + 1);
  localparam int PFW = $clog2(PEAK_BLOCKS + 1);
  localparam int DW  = RFW + $clog2(RMS_BLOCK_LEN + 1);
  localparam int SCW = (RMS_BLOCKS > PEAK_BLOCKS) ? RPW : PPW;
  localparam int QW  = TW;
  // The mean square never exceeds the square of the largest code.
  localparam int ROOTW = SB;
  localparam int QCW = $clog2(QW + 1);

  state_t state, state_next;

  logic [SB-1:0]  sample;
  logic [2*SB-1:0] sq;
  logic [IW-1:0]  sample_index;
  logic [RIW-1:0] rms_pos;
  logic           first_seen;
  logic [SB-1:0]  block_min, block_max;
  logic [SQW-1:0] square_accumulator;
  logic [PPW-1:0] peak_write_pos;
  logic [PFW-1:0] peak_fill;
  logic [RPW-1:0] square_write_pos;
  logic [RFW-1:0] square_fill;

  logic [SQW-1:0] square_ring [RMS_BLOCKS];
  logic [2*SB-1:0] peak_ring [PEAK_BLOCKS];  // {max, min}
  logic [SQW-1:0] sq_rd;
  logic [2*SB-1:0] pk_rd;

  logic [SCW:0]   scan;
  logic           scan_valid;
  logic [SCW:0]   scan_prev;
  logic [TW-1:0]  total;
  logic [SB-1:0]  lo, hi;

  logic [QW-1:0]  quot;
  logic [QW-1:0]  div_src;
  logic [DW:0]    rem;
  logic [DW-1:0]  divisor;
  logic [QCW-1:0] cnt;
  logic [ROOTW-1:0] root;
  logic [ROOTW+1:0] srem;
  logic [DW:0]    rem_shift;
  logic [ROOTW+1:0] srem_shift, strial;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_axis_tvalid) state_next = ST_UPDATE;
      ST_UPDATE:    state_next = ST_SCAN;
      ST_SCAN:      if (scan == (SCW+1)'(RMS_BLOCKS > PEAK_BLOCKS ? RMS_BLOCKS : PEAK_BLOCKS)
                        - (SCW+1)'(1))
                      state_next = ST_SCAN_LAST;
      ST_SCAN_LAST: state_next = ST_DIV;
      ST_DIV:       if (cnt == QCW'(QW - 1)) state_next = ST_SQRT;
      ST_SQRT:      if (cnt == QCW'(ROOTW - 1)) state_next = ST_OUT;
      ST_OUT:       if (m_axis_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    m_axis_tvalid = (state == ST_OUT);
    m_axis_tdata  = MW'({hi, lo, root});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring memories: one write port, one registered read port. Reads start in
  // the scan, after the update has written its entry.
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && rms_pos == '0) begin
      square_ring[square_write_pos] <= first_seen ? square_accumulator : SQW'(sq);
    end
    if (state == ST_UPDATE && sample_index == '0) begin
      peak_ring[peak_write_pos] <= first_seen ? {block_max, block_min} : {sample, sample};
    end
    sq_rd <= square_ring[RPW'(scan)];
    pk_rd <= peak_ring[PPW'(scan)];
  end

  assign sq = sample * sample;

  // Restoring divider and bit-serial square root steps.
  always_comb begin
    div_src    = (cnt == '0) ? total : quot;
    rem_shift  = {rem[DW-1:0], div_src[QW-1]};
    srem_shift = {srem[ROOTW-1:0], quot[2*SB-1 -: 2]};
    strial     = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      rms_pos <= '0;
      first_seen <= 1'b0;
      block_min <= '0;
      block_max <= '0;
      square_accumulator <= '0;
      peak_write_pos <= '0;
      peak_fill <= '0;
      square_write_pos <= '0;
      square_fill <= '0;
    end else if (state == ST_UPDATE) begin
      first_seen <= 1'b1;
      sample_index <= (sample_index == IW'(PEAK_BLOCK_LEN - 1)) ? '0 : sample_index + 1'b1;
      // rms_pos counts modulo the RMS block length and also restarts when sample_index wraps.
      rms_pos <= (sample_index == IW'(PEAK_BLOCK_LEN - 1) ||
                  rms_pos == RIW'(RMS_BLOCK_LEN - 1)) ? '0 : rms_pos + 1'b1;
      if (sample_index == '0) begin
        block_min <= sample;
        block_max <= sample;
        peak_write_pos <= (peak_write_pos == PPW'(PEAK_BLOCKS - 1)) ? '0
                          : peak_write_pos + 1'b1;
        if (peak_fill != PFW'(PEAK_BLOCKS)) peak_fill <= peak_fill + 1'b1;
      end else if (sample < block_min) begin
        block_min <= sample;
      end else if (sample > block_max) begin
        block_max <= sample;
      end
      if (rms_pos == '0) begin
        square_accumulator <= SQW'(sq);
        square_write_pos <= (square_write_pos == RPW'(RMS_BLOCKS - 1)) ? '0
                            : square_write_pos + 1'b1;
        if (square_fill != RFW'(RMS_BLOCKS)) square_fill <= square_fill + 1'b1;
      end else begin
        square_accumulator <= square_accumulator + SQW'(sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      sample <= s_axis_tdata[SB-1:0];
      scan <= '0;
    end
    if (state == ST_SCAN) begin
      scan <= scan + 1'b1;
      scan_valid <= 1'b1;
      scan_prev <= scan;
    end else begin
      scan_valid <= 1'b0;
    end
    if (state == ST_UPDATE) begin
      total <= '0;
    end
    if (scan_valid) begin
      if (scan_prev < (SCW+1)'(RMS_BLOCKS) && scan_prev < (SCW+1)'(square_fill))
        total <= total + TW'(sq_rd);
      if (scan_prev == '0) begin
        lo <= pk_rd[SB-1:0];
        hi <= pk_rd[2*SB-1:SB];
      end else if (scan_prev < (SCW+1)'(PEAK_BLOCKS) &&
                   scan_prev < (SCW+1)'(peak_fill)) begin
        if (pk_rd[SB-1:0] < lo) lo <= pk_rd[SB-1:0];
        if (pk_rd[2*SB-1:SB] > hi) hi <= pk_rd[2*SB-1:SB];
      end
    end
    if (state == ST_SCAN_LAST) begin
      cnt <= '0;
      rem <= '0;
      root <= '0;
      srem <= '0;
      divisor <= DW'(square_fill) * DW'(RMS_BLOCK_LEN);
    end
    if (state == ST_DIV) begin
      if (state_next == ST_SQRT) cnt <= '0;
      else cnt <= cnt + 1'b1;
      if (rem_shift >= {1'b0, divisor}) begin
        rem  <= rem_shift - {1'b0, divisor};
        quot <= {div_src[QW-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        quot <= {div_src[QW-2:0], 1'b0};
      end
    end
    if (state == ST_SQRT) begin
      cnt <= cnt + 1'b1;
      quot <= {quot[QW-3:0], 2'b00};
      if (srem_shift >= strial) begin
        srem <= srem_shift - strial;
        root <= {root[ROOTW-2:0], 1'b1};
      end else begin
        srem <= srem_shift;
        root <= {root[ROOTW-2:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/wrmmt_checker.sv */
`timescale 1ns / 1ps
`include "windowed_rms_min_max_tracker_core_macros.svh"
// ----------------------------------------------------------------------------
// wrmmt_checker
// Port-level checks for the tracker core.
// ----------------------------------------------------------------------------
module wrmmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  // One result at a time: no sample is taken while a result waits.
  `WRT_ASSERT_NOW(a_no_overlap, clk, rst, m_axis_tvalid, !s_axis_tready, "input ready during output")
  // An accepted sample is followed by work, not by an immediate result.
  `WRT_ASSERT_NEXT(a_latency, clk, rst, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result too early")
  // Minimum never exceeds maximum.
  `WRT_ASSERT_NOW(a_order, clk, rst, m_axis_tvalid, m_axis_tdata[23:12] <= m_axis_tdata[35:24], "min above max")
  // A stalled result holds its data.
  `WRT_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "data changed")
endmodule

bind windowed_rms_min_max_tracker_core wrmmt_checker u_wrmmt_checker (.*);
